// ----- design/prrs_pkg.sv -----
// ============================================================================
// prrs_pkg
// Shared types and constants of the priority round-robin scheduler.
// ============================================================================
`default_nettype none
package prrs_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_CREATE   = 3'd1;
    localparam logic [2:0] OP_STATUS   = 3'd2;
    localparam logic [2:0] OP_PREEMPT_EN  = 3'd3;
    localparam logic [2:0] OP_PREEMPT_DIS = 3'd4;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_WAITING = 2'd1;

    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_FULL = 2'd1;
    localparam logic [1:0] RES_SAT  = 2'd2;

    localparam logic [7:0] DEFAULT_SLICE = 8'd20;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_APPEND = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

// ----- design/priority_round_robin_scheduler_core.sv -----
// ============================================================================
// priority_round_robin_scheduler_core
// Task scheduler with a slot table and per-level FIFO ready queues.
// ============================================================================
// One item is taken at a time. A reschedule walks the ready queues through
// a single queue memory port, reading then checking each entry visited,
// level by level, then compacts the chosen queue entry by entry, with a read
// phase and a write phase for each. The result waits in an output
// register; the next item is taken once that register is free.
`default_nettype none
module priority_round_robin_scheduler_core #(
    parameter int MAX_TASKS  = 16,
    parameter int NUM_LEVELS = 3
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // opcode[2:0], new_status[4:3]
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,   // current_id[3:0], switched[4],
                                       // created_id[8:5], result_status[10:9]
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int QD = NUM_LEVELS * MAX_TASKS;
    localparam int QW = $clog2(QD);

    prrs_pkg::state_t state_reg;

    logic [7:0]      slice_reg;
    logic [LW-1:0]   prio_reg [MAX_TASKS];
    logic [1:0]      stat_reg [MAX_TASKS];
    logic [SW-1:0]   parent_reg [MAX_TASKS];
    logic [7:0]      pcnt_reg [MAX_TASKS];
    logic [CW-1:0]   qlen_reg [NUM_LEVELS];
    logic [SW-1:0]   qmem [QD];
    logic [SW-1:0]   qrd_reg;
    logic [SW-1:0]   cur_reg;
    logic [7:0]      ticks_reg;
    logic [CW-1:0]   free_reg;
    logic [2:0]      op_reg;
    logic [1:0]      nst_reg;
    logic [LW-1:0]   lv_reg;
    logic [CW-1:0]   idx_reg;
    logic [SW-1:0]   app_reg;
    logic [SW-1:0]   cand_reg;
    logic            sw_reg;
    logic [SW-1:0]   created_reg;
    logic [1:0]      res_reg;
    logic [15:0]     out_reg;
    logic            ovalid_reg;

    assign s_tready  = (state_reg == prrs_pkg::S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = out_reg;

    // level of a slot, clamped to the lowest level
    function automatic logic [LW-1:0] level_of(input logic [LW-1:0] p);
        if (32'(p) < NUM_LEVELS)
            return p;
        return LW'(NUM_LEVELS - 1);
    endfunction

    logic [LW-1:0] app_lv;
    logic [QW-1:0] qaddr;
    assign app_lv = level_of(prio_reg[app_reg]);

    // queue memory address of the entry under the scan/shift pointer
    always_comb
    begin
        qaddr = QW'(32'(lv_reg) * MAX_TASKS + 32'(idx_reg[SW-1:0]));
    end

    logic last_lv;
    assign last_lv = (32'(lv_reg) == NUM_LEVELS - 1);

    // queue memory: one write port, one registered read port
    logic          qwe;
    logic [QW-1:0] qwa;
    logic [SW-1:0] qwd;
    always_ff @(posedge clk)
    begin
        if (qwe)
            qmem[qwa] <= qwd;
        qrd_reg <= qmem[qaddr];
    end

    always_comb
    begin
        qwe = 1'b0;
        qwa = qaddr;
        qwd = qrd_reg;
        if (state_reg == prrs_pkg::S_SHIFT && idx_reg != '0 &&
            (32'(idx_reg) < 32'(qlen_reg[lv_reg]))) begin
            // move entry at idx into idx-1
            qwe = 1'b1;
            qwa = QW'(32'(qaddr) - 1);
        end
        else if (state_reg == prrs_pkg::S_APPEND &&
                 32'(qlen_reg[app_lv]) < MAX_TASKS) begin
            qwe = 1'b1;
            qwa = QW'(32'(app_lv) * MAX_TASKS + 32'(qlen_reg[app_lv]));
            qwd = app_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= prrs_pkg::S_IDLE;
            slice_reg  <= prrs_pkg::DEFAULT_SLICE;
            ticks_reg  <= prrs_pkg::DEFAULT_SLICE;
            cur_reg    <= '0;
            free_reg   <= CW'(1);
            ovalid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                stat_reg[i] <= prrs_pkg::ST_RUNNING;
                pcnt_reg[i] <= '0;
            end
            prio_reg[0] <= LW'(NUM_LEVELS - 1);
            for (int l = 0; l < NUM_LEVELS; l++)
                qlen_reg[l] <= '0;
            lv_reg <= '0;
            idx_reg <= '0;
            sw_reg <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                slice_reg <= cfg_data;
            if (m_tvalid && m_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                prrs_pkg::S_IDLE:
                begin
                    if (s_tvalid && s_tready) begin
                        op_reg  <= s_tdata[2:0];
                        nst_reg <= s_tdata[4:3];
                        state_reg <= prrs_pkg::S_EXEC;
                    end
                end
                prrs_pkg::S_EXEC:
                begin
                    sw_reg      <= 1'b0;
                    lv_reg      <= '0;
                    idx_reg     <= '0;
                    case (op_reg)
                        prrs_pkg::OP_TICK:
                        begin
                            created_reg <= '0;
                            res_reg     <= prrs_pkg::RES_OK;
                            if (ticks_reg <= 8'd1 && pcnt_reg[cur_reg] == 8'd0) begin
                                ticks_reg <= slice_reg;
                                state_reg <= prrs_pkg::S_SCAN;
                            end
                            else begin
                                ticks_reg <= (ticks_reg > 8'd1) ? ticks_reg - 8'd1 : 8'd0;
                                state_reg <= prrs_pkg::S_OUT;
                            end
                        end
                        prrs_pkg::OP_CREATE:
                        begin
                            if (32'(free_reg) < MAX_TASKS) begin
                                prio_reg[free_reg[SW-1:0]]   <= '0;
                                stat_reg[free_reg[SW-1:0]]   <= prrs_pkg::ST_RUNNING;
                                parent_reg[free_reg[SW-1:0]] <= cur_reg;
                                pcnt_reg[free_reg[SW-1:0]]   <= '0;
                                app_reg     <= free_reg[SW-1:0];
                                created_reg <= free_reg[SW-1:0];
                                res_reg     <= prrs_pkg::RES_OK;
                                free_reg    <= free_reg + CW'(1);
                                state_reg   <= prrs_pkg::S_APPEND;
                            end
                            else begin
                                created_reg <= '0;
                                res_reg     <= prrs_pkg::RES_FULL;
                                state_reg   <= prrs_pkg::S_OUT;
                            end
                        end
                        prrs_pkg::OP_STATUS:
                        begin
                            created_reg <= '0;
                            res_reg     <= prrs_pkg::RES_OK;
                            stat_reg[cur_reg] <= nst_reg;
                            if (nst_reg == prrs_pkg::ST_WAITING) begin
                                ticks_reg <= slice_reg;
                                state_reg <= prrs_pkg::S_SCAN;
                            end
                            else
                                state_reg <= prrs_pkg::S_OUT;
                        end
                        prrs_pkg::OP_PREEMPT_EN:
                        begin
                            created_reg <= '0;
                            state_reg   <= prrs_pkg::S_OUT;
                            if (pcnt_reg[cur_reg] == 8'd0)
                                res_reg <= prrs_pkg::RES_SAT;
                            else begin
                                res_reg <= prrs_pkg::RES_OK;
                                pcnt_reg[cur_reg] <= pcnt_reg[cur_reg] - 8'd1;
                            end
                        end
                        prrs_pkg::OP_PREEMPT_DIS:
                        begin
                            created_reg <= '0;
                            state_reg   <= prrs_pkg::S_OUT;
                            if (pcnt_reg[cur_reg] == 8'hFF)
                                res_reg <= prrs_pkg::RES_SAT;
                            else begin
                                res_reg <= prrs_pkg::RES_OK;
                                pcnt_reg[cur_reg] <= pcnt_reg[cur_reg] + 8'd1;
                            end
                        end
                        default:
                        begin
                            created_reg <= '0;
                            res_reg     <= prrs_pkg::RES_OK;
                            state_reg   <= prrs_pkg::S_OUT;
                        end
                    endcase
                end
                prrs_pkg::S_SCAN:
                begin
                    // qaddr is read this cycle; past end of level moves on
                    if (32'(idx_reg) >= 32'(qlen_reg[lv_reg]) ||
                        32'(idx_reg) >= MAX_TASKS) begin
                        idx_reg <= '0;
                        if (last_lv)
                            state_reg <= prrs_pkg::S_OUT;
                        else
                            lv_reg <= lv_reg + LW'(1);
                    end
                    else
                        state_reg <= prrs_pkg::S_CHECK;
                end
                prrs_pkg::S_CHECK:
                begin
                    if (stat_reg[qrd_reg] == prrs_pkg::ST_RUNNING) begin
                        cand_reg  <= qrd_reg;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= prrs_pkg::S_SHIFT;
                    end
                    else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= prrs_pkg::S_SCAN;
                    end
                end
                prrs_pkg::S_SHIFT:
                begin
                    // two-phase: read entry idx, then write it to idx-1
                    if (32'(idx_reg) >= 32'(qlen_reg[lv_reg]) ||
                        32'(idx_reg) >= MAX_TASKS) begin
                        qlen_reg[lv_reg] <= qlen_reg[lv_reg] - CW'(1);
                        app_reg   <= cur_reg;
                        cur_reg   <= cand_reg;
                        sw_reg    <= 1'b1;
                        state_reg <= prrs_pkg::S_APPEND;
                    end
                    else if (!sw_reg) begin
                        sw_reg <= 1'b1;       // read phase done
                    end
                    else begin
                        sw_reg  <= 1'b0;
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                prrs_pkg::S_APPEND:
                begin
                    if (32'(qlen_reg[app_lv]) < MAX_TASKS)
                        qlen_reg[app_lv] <= qlen_reg[app_lv] + CW'(1);
                    state_reg <= prrs_pkg::S_OUT;
                end
                prrs_pkg::S_OUT:
                begin
                    out_reg <= {5'd0, res_reg, 4'(created_reg), sw_reg, 4'(cur_reg)};
                    ovalid_reg <= 1'b1;
                    state_reg  <= prrs_pkg::S_IDLE;
                end
                default: state_reg <= prrs_pkg::S_IDLE;
            endcase
        end
    end

    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == prrs_pkg::S_EXEC))
        else $error("accepted item did not start execution");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != prrs_pkg::S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prrs_pkg::S_OUT) |=> ovalid_reg)
        else $error("result not posted");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while waiting");

endmodule
`default_nettype wire

// ----- bench/tb_priority_round_robin_scheduler_core.sv -----
// ============================================================================
// tb_priority_round_robin_scheduler_core
// Self-checking bench for the priority round-robin scheduler core: a local
// scheduler predictor computes each result, a scoreboard class compares them.
// ============================================================================
`default_nettype none
module tb_priority_round_robin_scheduler_core;

    localparam int NTASK = 16;
    localparam int NLVL  = 3;
    localparam int LIMIT = 3000000;

    // Expected-result store, checked in order
    class sched_scoreboard;
        logic [10:0] pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(logic [10:0] res);
            pending.push_back(res);
        endfunction

        function void check_result(logic [10:0] got);
            logic [10:0] exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_res = pending.pop_front();
                if (exp_res !== got)
                begin
                    $display("%0t mismatch: expected cur=%0d sw=%0d cr=%0d st=%0d,",
                        $time, exp_res[3:0], exp_res[4], exp_res[8:5], exp_res[10:9]);
                    $display("%0t          got cur=%0d sw=%0d cr=%0d st=%0d",
                        $time, got[3:0], got[4], got[8:5], got[10:9]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [15:0] m_tdata;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    priority_round_robin_scheduler_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Scheduler state of the predictor
    logic [7:0] slice_reg;
    logic [1:0] prio_tab[NTASK];
    logic [1:0] stat_tab[NTASK];
    logic [7:0] pcount_tab[NTASK];
    logic [3:0] ready_q[NLVL][$];
    logic [3:0] cur_task;
    logic [7:0] ticks_left;
    int         next_free;

    sched_scoreboard sb;
    int  cycle_count = 0;
    bit  quiet_in;
    bit  quiet_out;

    always #5 clk = ~clk;

    function automatic void reset_sched();
        for (int i = 0; i < NTASK; i++)
        begin
            prio_tab[i] = 2'd0;
            stat_tab[i] = prrs_pkg::ST_RUNNING;
            pcount_tab[i] = 8'd0;
        end
        for (int l = 0; l < NLVL; l++)
            ready_q[l].delete();
        prio_tab[0] = 2'(NLVL - 1);
        slice_reg = prrs_pkg::DEFAULT_SLICE;
        cur_task = 4'd0;
        ticks_left = prrs_pkg::DEFAULT_SLICE;
        next_free = 1;
    endfunction

    function automatic void enqueue_task(logic [3:0] slot);
        int lv;
        lv = (prio_tab[slot] < NLVL) ? prio_tab[slot] : NLVL - 1;
        if (ready_q[lv].size() < NTASK)
            ready_q[lv].push_back(slot);
    endfunction

    function automatic bit pick_next();
        logic [3:0] old_task;
        ticks_left = slice_reg;
        for (int l = 0; l < NLVL; l++)
            for (int i = 0; i < ready_q[l].size(); i++)
                if (stat_tab[ready_q[l][i]] == prrs_pkg::ST_RUNNING)
                begin
                    old_task = cur_task;
                    cur_task = ready_q[l][i];
                    ready_q[l].delete(i);
                    enqueue_task(old_task);
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    // Compute the result of one scheduler operation
    function automatic logic [10:0] predict_sched(logic [2:0] op, logic [1:0] st);
        logic [3:0] created;
        logic [1:0] res;
        bit         sw;
        created = 4'd0;
        res = prrs_pkg::RES_OK;
        sw = 1'b0;
        case (op)
            prrs_pkg::OP_TICK:
            begin
                if (ticks_left > 0)
                    ticks_left--;
                if (ticks_left == 0 && pcount_tab[cur_task] == 0)
                    sw = pick_next();
            end
            prrs_pkg::OP_CREATE:
            begin
                if (next_free < NTASK)
                begin
                    prio_tab[next_free] = 2'd0;
                    stat_tab[next_free] = prrs_pkg::ST_RUNNING;
                    pcount_tab[next_free] = 8'd0;
                    enqueue_task(4'(next_free));
                    created = 4'(next_free);
                    next_free++;
                end
                else
                    res = prrs_pkg::RES_FULL;
            end
            prrs_pkg::OP_STATUS:
            begin
                stat_tab[cur_task] = st;
                if (st == prrs_pkg::ST_WAITING)
                    sw = pick_next();
            end
            prrs_pkg::OP_PREEMPT_EN:
            begin
                if (pcount_tab[cur_task] == 0)
                    res = prrs_pkg::RES_SAT;
                else
                    pcount_tab[cur_task]--;
            end
            prrs_pkg::OP_PREEMPT_DIS:
            begin
                if (pcount_tab[cur_task] == 8'hFF)
                    res = prrs_pkg::RES_SAT;
                else
                    pcount_tab[cur_task]++;
            end
            default: ;
        endcase
        return {res, created, sw, cur_task};
    endfunction

    // Send one item, noting its expected result on acceptance
    task automatic send_item(logic [2:0] op, logic [1:0] st);
        while (!quiet_in && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, st, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(predict_sched(op, st));
    endtask

    // Write the slice register once nothing is outstanding
    task automatic write_slice(logic [7:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        slice_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Random operation: mostly ticks, some status, preempt and create traffic, and unknown ops
    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_item(prrs_pkg::OP_TICK, 2'($urandom));
        else if (pick < 62)
            send_item(prrs_pkg::OP_CREATE, 2'($urandom));
        else if (pick < 80)
            send_item(prrs_pkg::OP_STATUS, 2'($urandom));
        else if (pick < 88)
            send_item(prrs_pkg::OP_PREEMPT_EN, 2'($urandom));
        else if (pick < 96)
            send_item(prrs_pkg::OP_PREEMPT_DIS, 2'($urandom));
        else
            send_item(3'($urandom_range(7, 5)), 2'($urandom));
    endtask

    // Result side: random stall, check on each accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[10:0]);
            m_tready <= quiet_out || ($urandom_range(99) >= 14);
        end
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        reset_sched();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: saturation, create, unknown ops and waiting
        send_item(prrs_pkg::OP_PREEMPT_EN, 2'd0);
        send_item(prrs_pkg::OP_PREEMPT_DIS, 2'd3);
        send_item(prrs_pkg::OP_TICK, 2'd0);
        send_item(prrs_pkg::OP_PREEMPT_EN, 2'd0);
        send_item(3'd5, 2'd1);
        send_item(3'd7, 2'd2);
        send_item(prrs_pkg::OP_CREATE, 2'd0);
        send_item(prrs_pkg::OP_CREATE, 2'd0);
        send_item(prrs_pkg::OP_STATUS, prrs_pkg::ST_WAITING);
        send_item(prrs_pkg::OP_STATUS, 2'd2);
        send_item(prrs_pkg::OP_STATUS, prrs_pkg::ST_WAITING);
        send_item(prrs_pkg::OP_STATUS, 2'd3);
        send_item(prrs_pkg::OP_STATUS, prrs_pkg::ST_RUNNING);
        for (int i = 0; i < 20; i++)
            send_item(prrs_pkg::OP_TICK, 2'd0);
        write_slice(8'd1);
        for (int i = 0; i < 6; i++)
            send_item(prrs_pkg::OP_TICK, 2'd0);

        // Hold preemption at the top count, then tick at spent slice;
        // run this long stretch with no idling on either side
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        for (int i = 0; i < 256; i++)
            send_item(prrs_pkg::OP_PREEMPT_DIS, 2'd0);
        send_item(prrs_pkg::OP_TICK, 2'd0);
        send_item(prrs_pkg::OP_TICK, 2'd0);
        for (int i = 0; i < 255; i++)
            send_item(prrs_pkg::OP_PREEMPT_EN, 2'd0);
        send_item(prrs_pkg::OP_TICK, 2'd0);
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        // Random phases over several slice settings, extremes included
        write_slice(8'd0);
        for (int i = 0; i < 10; i++)
            send_random();
        write_slice(8'd3);
        for (int i = 0; i < 10; i++)
            send_random();
        for (int i = 0; i < 16; i++)
            send_item(prrs_pkg::OP_CREATE, 2'd0);
        write_slice(8'd255);
        for (int i = 0; i < 10; i++)
            send_random();
        write_slice(8'($urandom_range(2, 8)));
        for (int i = 0; i < 10; i++)
            send_random();

        // Drain
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
